@@ rtl/core/otq_pkg.sv @@
// Shared types, codes and defaults for the ordered timer expiry queue.
package otq_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_RESULTS   = 32;

  // input mode codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DEL    = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // classified operation codes
  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  slot_id;
    logic [47:0] expire_at;
    logic [31:0] repeat_interval;
    logic [47:0] now_time;
  } in_t;

  typedef struct packed {
    logic        fired;
    logic [4:0]  fired_id;
    logic        last;
    logic [47:0] next_deadline;
    logic        queue_empty;
  } out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  slot;
    logic [47:0] expire;
    logic [31:0] interval;
    logic [47:0] now;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_ch_t;

endpackage

@@ rtl/core/otq_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module otq_front #(
  parameter int NUM_SLOTS = otq_pkg::NUM_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  otq_pkg::in_t    in_data,
  output otq_pkg::cmd_ch_t cmd_ch,
  input  logic            cmd_pop
);

  otq_pkg::cmd_t fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  otq_pkg::cmd_t cls;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign pop  = cmd_pop && (cnt_r != 2'd0);

  // classify the request
  always_comb begin
    logic in_range;
    in_range     = ({27'd0, in_data.slot_id} < 32'(NUM_SLOTS));
    cls.slot     = in_data.slot_id;
    cls.expire   = in_data.expire_at;
    cls.interval = in_data.repeat_interval;
    cls.now      = in_data.now_time;
    case (in_data.mode)
      otq_pkg::MODE_ADD:  cls.op = in_range ? otq_pkg::OP_ADD : otq_pkg::OP_NOP;
      otq_pkg::MODE_DEL:  cls.op = in_range ? otq_pkg::OP_DEL : otq_pkg::OP_NOP;
      otq_pkg::MODE_TICK: cls.op = otq_pkg::OP_TICK;
      default:            cls.op = otq_pkg::OP_NOP;
    endcase
  end

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  assign cmd_ch.valid = (cnt_r != 2'd0);
  assign cmd_ch.cmd   = fifo_r[rd_ptr_r];

endmodule

@@ rtl/core/otq_back.sv @@
// Back end: timer table, ordered expiry scan, rearm and result sequencing.
module otq_back #(
  parameter int NUM_SLOTS = otq_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = otq_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  otq_pkg::cmd_ch_t cmd_ch,
  output logic             cmd_pop,
  output logic             out_valid,
  output otq_pkg::out_t    out_data
);

  localparam int IDW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCW = IDW + 1;
  localparam int MIW = $clog2(otq_pkg::MAX_RESULTS);
  localparam int CW  = MIW + 1;
  localparam int SW  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // slot tables
  logic [TIME_BITS-1:0] exp_mem [NUM_SLOTS];
  logic [31:0]          iv_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_r, act_nxt;
  logic [TIME_BITS-1:0] exp_rd_r;
  logic [31:0]          iv_rd_r;

  logic                 exp_we, iv_we, rd_en;
  logic [IDW-1:0]       wr_addr, rd_addr;
  logic [TIME_BITS-1:0] exp_wd;

  logic [2:0]           state_r, state_nxt;
  otq_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [SCW-1:0]       sc_r, sc_nxt;
  logic                 pv_r, pv_nxt;
  logic [IDW-1:0]       pidx_r, pidx_nxt;
  logic                 stat_r, stat_nxt;
  logic                 found_r, found_nxt;
  logic [TIME_BITS-1:0] best_exp_r, best_exp_nxt;
  logic [IDW-1:0]       best_id_r, best_id_nxt;
  logic [31:0]          best_iv_r, best_iv_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [MIW-1:0]       em_r, em_nxt;
  logic [IDW-1:0]       ids_r [otq_pkg::MAX_RESULTS];
  logic                 ids_we;
  logic [47:0]          dl_r, dl_nxt;
  logic                 empty_r, empty_nxt;
  logic                 ov_r, ov_nxt;
  otq_pkg::out_t        od_r, od_nxt;

  logic [TIME_BITS-1:0] now_t, add_exp;
  logic [IDW-1:0]       cmd_slot;
  logic                 hit;
  logic [SW-1:0]        rearm_sum;
  logic [TIME_BITS-1:0] rearm_val;
  logic                 em_last;

  assign now_t    = TIME_BITS'(cmd_r.now);
  assign add_exp  = TIME_BITS'(cmd_r.expire);
  assign cmd_slot = IDW'(cmd_r.slot);

  // candidate test on the slot that just came out of the table
  assign hit = pv_r && act_r[pidx_r] && (stat_r || (exp_rd_r < now_t))
               && (!found_r || (exp_rd_r < best_exp_r));

  // saturating rearm time
  assign rearm_sum = SW'(now_t) + SW'(best_iv_r);
  assign rearm_val = (rearm_sum[SW-1:TIME_BITS] != '0) ? TMAX : rearm_sum[TIME_BITS-1:0];

  assign em_last = (cnt_r == '0) || ({1'b0, em_r} == cnt_r - CW'(1));

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    sc_nxt       = sc_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    stat_nxt     = stat_r;
    found_nxt    = found_r;
    best_exp_nxt = best_exp_r;
    best_id_nxt  = best_id_r;
    best_iv_nxt  = best_iv_r;
    cnt_nxt      = cnt_r;
    em_nxt       = em_r;
    dl_nxt       = dl_r;
    empty_nxt    = empty_r;
    act_nxt      = act_r;
    ov_nxt       = 1'b0;
    od_nxt       = od_r;
    cmd_pop      = 1'b0;
    exp_we       = 1'b0;
    iv_we        = 1'b0;
    wr_addr      = cmd_slot;
    exp_wd       = add_exp;
    rd_en        = 1'b0;
    rd_addr      = sc_r[IDW-1:0];
    ids_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_ch.valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_ch.cmd;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // apply add or delete, then start the first scan
        if (cmd_r.op == otq_pkg::OP_ADD) begin
          exp_we            = 1'b1;
          iv_we             = 1'b1;
          act_nxt[cmd_slot] = 1'b1;
        end else if (cmd_r.op == otq_pkg::OP_DEL) begin
          act_nxt[cmd_slot] = 1'b0;
        end
        cnt_nxt   = '0;
        stat_nxt  = (cmd_r.op != otq_pkg::OP_TICK);
        sc_nxt    = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // issue reads in slot order and keep the earliest candidate
        if (sc_r != SCW'(NUM_SLOTS)) begin
          rd_en    = 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = sc_r[IDW-1:0];
          sc_nxt   = sc_r + SCW'(1);
        end
        if (hit) begin
          found_nxt    = 1'b1;
          best_exp_nxt = exp_rd_r;
          best_id_nxt  = pidx_r;
          best_iv_nxt  = iv_rd_r;
        end
        if (sc_r == SCW'(NUM_SLOTS) && !pv_r) begin
          if (stat_r) begin
            dl_nxt    = found_r ? 48'(64'(best_exp_r)) : 48'd0;
            empty_nxt = !found_r;
            em_nxt    = '0;
            state_nxt = S_EMIT;
          end else if (found_r) begin
            state_nxt = S_UPD;
          end else begin
            stat_nxt  = 1'b1;
            sc_nxt    = '0;
          end
        end
      end
      S_UPD: begin
        // rearm or free the picked slot and record it
        wr_addr = best_id_r;
        exp_wd  = rearm_val;
        if (best_iv_r != 32'd0) begin
          exp_we = 1'b1;
        end else begin
          act_nxt[best_id_r] = 1'b0;
        end
        ids_we    = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        stat_nxt  = (cnt_r + CW'(1) == CW'(otq_pkg::MAX_RESULTS));
        sc_nxt    = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_EMIT: begin
        // drive one result per cycle
        ov_nxt               = 1'b1;
        od_nxt.fired         = (cnt_r != '0);
        od_nxt.fired_id      = (cnt_r != '0) ? 5'(32'(ids_r[em_r])) : 5'd0;
        od_nxt.last          = em_last;
        od_nxt.next_deadline = dl_r;
        od_nxt.queue_empty   = empty_r;
        em_nxt               = em_r + MIW'(1);
        if (em_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sc_r       <= sc_nxt;
    pidx_r     <= pidx_nxt;
    stat_r     <= stat_nxt;
    found_r    <= found_nxt;
    best_exp_r <= best_exp_nxt;
    best_id_r  <= best_id_nxt;
    best_iv_r  <= best_iv_nxt;
    cnt_r      <= cnt_nxt;
    em_r       <= em_nxt;
    dl_r       <= dl_nxt;
    empty_r    <= empty_nxt;
    od_r       <= od_nxt;
    if (ids_we) begin
      ids_r[cnt_r[MIW-1:0]] <= best_id_r;
    end
  end

  // expiry table
  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[wr_addr] <= exp_wd;
    end
    if (rd_en) begin
      exp_rd_r <= exp_mem[rd_addr];
    end
  end

  // interval table
  always_ff @(posedge clk) begin
    if (iv_we) begin
      iv_mem[wr_addr] <= cmd_r.interval;
    end
    if (rd_en) begin
      iv_rd_r <= iv_mem[rd_addr];
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

@@ rtl/core/ordered_timer_expiry_queue_core.sv @@
// Top level of the ordered timer expiry queue.
// Usage:
//   A request (add, delete or tick) is taken at a rising edge with start high
//   and busy low. Requests enter a two-entry queue; busy is high while it is
//   full. Each request produces one or more results on out_data, each shown
//   for exactly one cycle with out_valid high; the last one carries last=1.
//   A tick reports every active timer earlier than now_time in ascending
//   expiry order (ties by lower slot), up to 32 per tick, rearming repeating
//   timers and freeing one-shot ones. Every result carries the deadline and
//   empty flag after the whole request.
// Timing:
//   Every table scan reads one slot per cycle from the expiry and interval
//   memories. Results of one request leave on consecutive cycles.
// Reset clears every active mark and empties the request queue; the
//   receiver cannot stall results.
module ordered_timer_expiry_queue_core #(
  parameter int NUM_SLOTS = otq_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = otq_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  otq_pkg::in_t  in_data,
  output logic          out_valid,
  output otq_pkg::out_t out_data
);

  otq_pkg::cmd_ch_t cmd_ch;
  logic             cmd_pop;

  otq_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .cmd_ch  (cmd_ch),
    .cmd_pop (cmd_pop)
  );

  otq_back #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ch    (cmd_ch),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("result burst broken");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last)
    else $error("status result not last");
  a_empty_dl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.queue_empty |-> out_data.next_deadline == 48'd0)
    else $error("empty queue with deadline");
`endif

endmodule

@@ tb/otq_checker.sv @@
// Checker for the timer expiry queue: tracks the slot table and compares every result.
module otq_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  otq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  otq_pkg::out_t out_data,
  output int            fail_count,
  output int            pending,
  output int            fired_seen
);

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  logic [47:0]   exp_time [32];
  logic [31:0]   rearm_iv [32];
  logic          armed    [32];
  otq_pkg::out_t expected_q [$];

  // work out the results of one request and update the table
  task automatic predict_request(input otq_pkg::in_t req);
    int            picked [$];
    int            n, j, s;
    logic [47:0]   best;
    logic          any;
    otq_pkg::out_t r;
    begin
      if (req.mode == otq_pkg::MODE_ADD) begin
        exp_time[req.slot_id] = req.expire_at;
        rearm_iv[req.slot_id] = req.repeat_interval;
        armed[req.slot_id] = 1'b1;
      end else if (req.mode == otq_pkg::MODE_DEL) begin
        armed[req.slot_id] = 1'b0;
      end else if (req.mode == otq_pkg::MODE_TICK) begin
        // insert expired slots in (expiry, id) order, keep the earliest MAX_RESULTS
        for (int i = 0; i < 32; i++) begin
          if (armed[i] && exp_time[i] < req.now_time) begin
            j = 0;
            while (j < picked.size() && exp_time[picked[j]] <= exp_time[i]) j++;
            picked.insert(j, i);
            if (picked.size() > otq_pkg::MAX_RESULTS) void'(picked.pop_back());
          end
        end
        foreach (picked[k]) begin
          s = picked[k];
          if (rearm_iv[s] != 0) begin
            if ({16'd0, rearm_iv[s]} > TMAX - req.now_time) exp_time[s] = TMAX;
            else exp_time[s] = req.now_time + {16'd0, rearm_iv[s]};
          end else begin
            armed[s] = 1'b0;
          end
        end
      end
      any = 1'b0;
      best = '0;
      for (int i = 0; i < 32; i++)
        if (armed[i] && (!any || exp_time[i] < best)) begin
          best = exp_time[i];
          any = 1'b1;
        end
      n = picked.size();
      r.next_deadline = best;
      r.queue_empty = !any;
      if (n == 0) begin
        r.fired = 1'b0;
        r.fired_id = '0;
        r.last = 1'b1;
        expected_q = {expected_q, r};
      end
      for (int k = 0; k < n; k++) begin
        r.fired = 1'b1;
        r.fired_id = 5'(picked[k]);
        r.last = (k == n - 1);
        expected_q = {expected_q, r};
      end
    end
  endtask

  // compare one result with the oldest expectation
  task automatic check_result(input otq_pkg::out_t got);
    otq_pkg::out_t e;
    begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", got);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (got.fired !== e.fired) begin
          $error("fired: expected %0d, got %0d", e.fired, got.fired); fail_count++;
        end
        if (got.fired_id !== e.fired_id) begin
          $error("fired_id: expected %0d, got %0d", e.fired_id, got.fired_id); fail_count++;
        end
        if (got.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, got.last); fail_count++;
        end
        if (got.next_deadline !== e.next_deadline) begin
          $error("next_deadline: expected %0h, got %0h", e.next_deadline, got.next_deadline);
          fail_count++;
        end
        if (got.queue_empty !== e.queue_empty) begin
          $error("queue_empty: expected %0d, got %0d", e.queue_empty, got.queue_empty);
          fail_count++;
        end
        if (e.fired) fired_seen++;
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (armed[i]) armed[i] = 1'b0;
      expected_q.delete();
      fail_count = 0;
      fired_seen = 0;
    end else begin
      if (out_valid) check_result(out_data);
      if (start && !busy) predict_request(in_data);
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/tb_ordered_timer_expiry_queue_core.sv @@
// Testbench top for the timer expiry queue: stimulus, phases and verdict.
module tb_ordered_timer_expiry_queue_core;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  otq_pkg::in_t  in_data = '0;
  logic          out_valid;
  otq_pkg::out_t out_data;
  int    fail_count, pending, fired_seen;
  int    cycle_count = 0;
  int    gap_pct = 0;
  int    sent = 0;
  logic [47:0] clock_now = 48'd1000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ordered_timer_expiry_queue_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  otq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending(pending), .fired_seen(fired_seen)
  );

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb_ordered_timer_expiry_queue_core: done, errors");
      $finish;
    end
  end

  // drive one request and hold it until accepted
  task automatic send_request(input otq_pkg::in_t req);
    begin
      while ($urandom_range(99) < gap_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
      start <= 1'b1;
      in_data <= req;
      @(posedge clk);
      while (busy) @(posedge clk);
      @(negedge clk);
      sent++;
    end
  endtask

  function automatic otq_pkg::in_t make_req(input logic [1:0] m, input logic [4:0] s,
                                            input logic [47:0] e, input logic [31:0] iv,
                                            input logic [47:0] t);
    otq_pkg::in_t r;
    r.mode = m; r.slot_id = s; r.expire_at = e; r.repeat_interval = iv; r.now_time = t;
    return r;
  endfunction

  // random request: adds near the current time, deletes, ticks advancing time, unused modes
  task automatic send_random();
    int          pick;
    logic [31:0] iv;
    logic [47:0] e;
    begin
      pick = $urandom_range(99);
      iv = ($urandom_range(2) == 0) ? 32'd0 :
           ($urandom_range(9) == 0) ? $urandom : $urandom_range(400, 1);
      e = ($urandom_range(15) == 0) ? 48'({$urandom, $urandom})
                                    : clock_now + 48'($urandom_range(300));
      if (pick < 45)
        send_request(make_req(otq_pkg::MODE_ADD, 5'($urandom), e, iv,
                              48'({$urandom, $urandom})));
      else if (pick < 60)
        send_request(make_req(otq_pkg::MODE_DEL, 5'($urandom), 48'({$urandom, $urandom}),
                              $urandom, 48'({$urandom, $urandom})));
      else if (pick < 95) begin
        clock_now = clock_now + 48'($urandom_range(200));
        send_request(make_req(otq_pkg::MODE_TICK, 5'($urandom), 48'({$urandom, $urandom}),
                              $urandom, clock_now));
      end else
        send_request(make_req(otq_pkg::MODE_UNUSED, 5'($urandom), 48'({$urandom, $urandom}),
                              $urandom, 48'({$urandom, $urandom})));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty tick, extremes, tie order, overflow, delete cases, mode 3
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'hFFFF_FFFF_FFFF));
    send_request(make_req(otq_pkg::MODE_DEL, 5'd7, '0, '0, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd31, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd0, 48'd0, 32'd0, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd4, 48'd10, 32'd5, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd2, 48'd10, 32'd0, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd3, 48'd10, 32'd0, '0));
    send_request(make_req(otq_pkg::MODE_DEL, 5'd3, '0, '0, '0));
    send_request(make_req(otq_pkg::MODE_ADD, 5'd2, 48'd9, 32'd1, '0));
    send_request(make_req(otq_pkg::MODE_UNUSED, 5'd9, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                          48'hFFFF_FFFF_FFFF));
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'd10));
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'd11));
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'hFFFF_FFFF_FFFF));
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'hFFFF_FFFF_FFFF));
    // fill every slot with the same expiry, then fire all 32 at once
    for (int i = 0; i < 32; i++)
      send_request(make_req(otq_pkg::MODE_ADD, 5'(i), 48'd500,
                            (i % 2) ? 32'd0 : 32'd7, '0));
    send_request(make_req(otq_pkg::MODE_TICK, 5'd0, '0, '0, 48'd501));
    for (int i = 0; i < 32; i++)
      send_request(make_req(otq_pkg::MODE_DEL, 5'(i), '0, '0, '0));

    // random phases; phases 1 and 3 add sender gaps
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 77 : (ph == 3) ? 16 : 0;
      repeat (58) send_random();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d timer expirations reported", sent, fired_seen);
    if (fail_count == 0)
      $display("tb_ordered_timer_expiry_queue_core: done, clean");
    else
      $display("tb_ordered_timer_expiry_queue_core: done, errors");
    $finish;
  end
endmodule
